@@ hw/rtl/bwt_pkg.sv @@
// ----------------------------------------------------------------------------
// bwt_pkg
// Shared constants, codes and types of the breakpoint and watchpoint table.
// ----------------------------------------------------------------------------
`default_nettype none

package bwt_pkg;

  // Table sizes.
  localparam int BREAK_SLOTS = 8;
  localparam int WATCH_SLOTS = 8;
  localparam int SLOT_MAX    = (BREAK_SLOTS > WATCH_SLOTS) ? BREAK_SLOTS : WATCH_SLOTS;

  // Index widths, never below one bit.
  localparam int IDX_W     = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
  localparam int BRK_IDX_W = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int WCH_IDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;

  // Command codes.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_CHECK  = 3'd4;

  // Table selector.
  localparam logic KIND_BREAK = 1'b0;
  localparam logic KIND_WATCH = 1'b1;

  // Status codes.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_MISS       = 2'd1;
  localparam logic [1:0] STAT_UNREADABLE = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // Table update kinds.
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_ADD    = 3'd1,
    WR_REMOVE = 3'd2,
    WR_TOGGLE = 3'd3,
    WR_LAST   = 3'd4
  } wr_op_t;

  // Update request from the sequencer to the slot store.
  typedef struct packed {
    wr_op_t              wop;
    logic                kind;
    idx_t                idx;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   last;
    logic                flag;
  } wr_req_t;

  // One slot as read from the store.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   last;
    logic                used;
    logic                enabled;
  } slot_rd_t;

endpackage

`default_nettype wire

@@ hw/rtl/bwt_cmd_if.sv @@
// ----------------------------------------------------------------------------
// bwt_cmd_if
// Command channel of the trigger table: valid/ready with the command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        kind;
  logic [31:0] address;
  logic        enable_flag;
  logic [2:0]  slot;
  logic [31:0] mem_value;
  logic        mem_ok;

  modport source (
    output valid, op, kind, address, enable_flag, slot, mem_value, mem_ok,
    input  ready
  );

  modport sink (
    input  valid, op, kind, address, enable_flag, slot, mem_value, mem_ok,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/bwt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bwt_rsp_if
// Response channel of the trigger table: valid/ready with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] found_slot;
  logic       changed;

  modport source (
    output valid, status, found_slot, changed,
    input  ready
  );

  modport sink (
    input  valid, status, found_slot, changed,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/bwt_store.sv @@
// ----------------------------------------------------------------------------
// bwt_store
// Slot store of both tables: one read port at a chosen slot, one update port.
// ----------------------------------------------------------------------------
`default_nettype none

module bwt_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_kind,
  input  wire bwt_pkg::idx_t     rd_idx,
  output bwt_pkg::slot_rd_t      rd,
  input  wire bwt_pkg::wr_req_t  wr
);

  logic [bwt_pkg::ADDR_W-1:0] brk_addr [bwt_pkg::BREAK_SLOTS];
  logic [bwt_pkg::ADDR_W-1:0] wch_addr [bwt_pkg::WATCH_SLOTS];
  logic [bwt_pkg::DATA_W-1:0] wch_last [bwt_pkg::WATCH_SLOTS];
  logic [bwt_pkg::BREAK_SLOTS-1:0] brk_used;
  logic [bwt_pkg::BREAK_SLOTS-1:0] brk_enabled;
  logic [bwt_pkg::WATCH_SLOTS-1:0] wch_used;
  logic [bwt_pkg::WATCH_SLOTS-1:0] wch_enabled;

  logic [bwt_pkg::BRK_IDX_W-1:0] rd_brk;
  logic [bwt_pkg::WCH_IDX_W-1:0] rd_wch;
  logic [bwt_pkg::BRK_IDX_W-1:0] wr_brk;
  logic [bwt_pkg::WCH_IDX_W-1:0] wr_wch;

  assign rd_brk = rd_idx[bwt_pkg::BRK_IDX_W-1:0];
  assign rd_wch = rd_idx[bwt_pkg::WCH_IDX_W-1:0];
  assign wr_brk = wr.idx[bwt_pkg::BRK_IDX_W-1:0];
  assign wr_wch = wr.idx[bwt_pkg::WCH_IDX_W-1:0];

  always_comb begin
    if (rd_kind == bwt_pkg::KIND_WATCH) begin
      rd.addr    = wch_addr[rd_wch];
      rd.used    = wch_used[rd_wch];
      rd.enabled = wch_enabled[rd_wch];
    end else begin
      rd.addr    = brk_addr[rd_brk];
      rd.used    = brk_used[rd_brk];
      rd.enabled = brk_enabled[rd_brk];
    end
    rd.last = wch_last[rd_wch];
  end

  // Flag bits are control state and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      brk_used    <= '0;
      brk_enabled <= '0;
      wch_used    <= '0;
      wch_enabled <= '0;
    end else begin
      unique case (wr.wop)
        bwt_pkg::WR_ADD: begin
          if (wr.kind == bwt_pkg::KIND_WATCH) begin
            wch_used[wr_wch]    <= 1'b1;
            wch_enabled[wr_wch] <= 1'b1;
          end else begin
            brk_used[wr_brk]    <= 1'b1;
            brk_enabled[wr_brk] <= 1'b1;
          end
        end
        bwt_pkg::WR_REMOVE: begin
          if (wr.kind == bwt_pkg::KIND_WATCH) begin
            wch_used[wr_wch] <= 1'b0;
          end else begin
            brk_used[wr_brk] <= 1'b0;
          end
        end
        bwt_pkg::WR_TOGGLE: begin
          if (wr.kind == bwt_pkg::KIND_WATCH) begin
            wch_enabled[wr_wch] <= wr.flag;
          end else begin
            brk_enabled[wr_brk] <= wr.flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Addresses and values are only read from slots that are in use, and every
  // slot is written in full when it is taken, so they need no reset.
  always_ff @(posedge clk) begin
    unique case (wr.wop)
      bwt_pkg::WR_ADD: begin
        if (wr.kind == bwt_pkg::KIND_WATCH) begin
          wch_addr[wr_wch] <= wr.addr;
          wch_last[wr_wch] <= wr.last;
        end else begin
          brk_addr[wr_brk] <= wr.addr;
        end
      end
      bwt_pkg::WR_LAST: begin
        wch_last[wr_wch] <= wr.last;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/break_watch_trigger_table_core.sv @@
// Sequence: add, remove, toggle and find pass through SCAN, which walks the addressed
//   table (8 slots here) and stops early on a match, then through APPLY and RESP; a
//   check passes through CHECK and RESP; an unused op goes straight to RESP.
// Commands are taken one at a time, a new one only in IDLE after the last response;
//   the single shared comparator walks the table one slot per cycle.
// Reset: synchronous, active high; all slots become free and inactive, no response pending.
// ----------------------------------------------------------------------------
// break_watch_trigger_table_core
// Breakpoint and watchpoint tables with a slot-serial lookup sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module break_watch_trigger_table_core (
  input  wire logic clk,
  input  wire logic rst,
  bwt_cmd_if.sink   cmd,
  bwt_rsp_if.source rsp
);

  // The sequencer is one-hot. IDLE waits for a command, SCAN walks the
  // selected table one slot per cycle, APPLY commits the outcome of a scan,
  // CHECK compares one watch slot with the fresh memory word, and RESP holds
  // the result until the response transfer completes.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_CHECK = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;

  // Latched command.
  logic [2:0]                 op_q;
  logic                       kind_q;
  logic [bwt_pkg::ADDR_W-1:0] addr_q;
  logic                       flag_q;
  logic [bwt_pkg::DATA_W-1:0] mval_q;
  logic                       mok_q;

  // Scan bookkeeping.
  bwt_pkg::idx_t idx;
  logic          hit;
  bwt_pkg::idx_t hit_idx;
  logic          free_ok;
  bwt_pkg::idx_t free_idx;

  // Result registers, shown on the response channel in RESP.
  logic [1:0] status_q;
  logic [2:0] found_q;
  logic       changed_q;

  bwt_pkg::slot_rd_t rd;
  bwt_pkg::wr_req_t  wr;
  logic              rd_kind;

  logic                       cmd_xfer;
  logic                       rsp_xfer;
  logic                       last_slot;
  logic                       slot_match;
  logic                       check_changed;
  logic [bwt_pkg::DATA_W-1:0] cmp_a;
  logic [bwt_pkg::DATA_W-1:0] cmp_b;
  logic                       cmp_eq;
  logic                       slot_in_range;

  assign cmd_xfer = cmd.valid && cmd.ready;
  assign rsp_xfer = rsp.valid && rsp.ready;

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = (state == S_RESP);
  assign rsp.status     = status_q;
  assign rsp.found_slot = found_q;
  assign rsp.changed    = changed_q;

  // A check always reads the watch table, whatever kind says.
  assign rd_kind = (state == S_CHECK) ? bwt_pkg::KIND_WATCH : kind_q;

  bwt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_kind (rd_kind),
    .rd_idx  (idx),
    .rd      (rd),
    .wr      (wr)
  );

  // The one shared equality comparator: slot address against the command
  // address during a scan, stored value against the fresh word in a check.
  always_comb begin
    if (state == S_CHECK) begin
      cmp_a = rd.last;
      cmp_b = mval_q;
    end else begin
      cmp_a = rd.addr;
      cmp_b = addr_q;
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  assign slot_match    = rd.used && cmp_eq;
  assign check_changed = rd.used && rd.enabled && mok_q && !cmp_eq;

  // The scan ends on the final slot of whichever table is addressed.
  always_comb begin
    if (kind_q == bwt_pkg::KIND_WATCH) begin
      last_slot = (idx == bwt_pkg::IDX_W'(bwt_pkg::WATCH_SLOTS - 1));
    end else begin
      last_slot = (idx == bwt_pkg::IDX_W'(bwt_pkg::BREAK_SLOTS - 1));
    end
  end

  assign slot_in_range = (int'(cmd.slot) < bwt_pkg::WATCH_SLOTS);

  // Table updates are issued only in APPLY and CHECK.
  always_comb begin
    wr.wop  = bwt_pkg::WR_NONE;
    wr.kind = kind_q;
    wr.idx  = hit_idx;
    wr.addr = addr_q;
    wr.last = mok_q ? mval_q : '0;
    wr.flag = flag_q;
    if (state == S_APPLY) begin
      if (op_q == bwt_pkg::OP_ADD && !hit && free_ok) begin
        wr.wop = bwt_pkg::WR_ADD;
        wr.idx = free_idx;
      end else if (op_q == bwt_pkg::OP_REMOVE && hit) begin
        wr.wop = bwt_pkg::WR_REMOVE;
      end else if (op_q == bwt_pkg::OP_TOGGLE && hit) begin
        wr.wop = bwt_pkg::WR_TOGGLE;
      end
    end else if (state == S_CHECK) begin
      wr.kind = bwt_pkg::KIND_WATCH;
      wr.idx  = idx;
      wr.last = mval_q;
      if (check_changed) begin
        wr.wop = bwt_pkg::WR_LAST;
      end
    end
  end

  // Payload registers of the sequencer; they need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_q      <= cmd.op;
        kind_q    <= cmd.kind;
        addr_q    <= cmd.address;
        flag_q    <= cmd.enable_flag;
        mval_q    <= cmd.mem_value;
        mok_q     <= cmd.mem_ok;
        changed_q <= 1'b0;
        if (cmd.op == bwt_pkg::OP_CHECK) begin
          idx <= bwt_pkg::IDX_W'(cmd.slot);
        end else begin
          idx <= '0;
        end
        if (cmd.op == bwt_pkg::OP_CHECK && slot_in_range) begin
          status_q <= bwt_pkg::STAT_OK;
          found_q  <= cmd.slot;
        end else begin
          status_q <= bwt_pkg::STAT_MISS;
          found_q  <= 3'd0;
        end
        hit     <= 1'b0;
        free_ok <= 1'b0;
      end
      S_SCAN: begin
        // Remember the lowest free slot for a later add.
        if (!rd.used && !free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= idx;
        end
        if (slot_match) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end else if (!last_slot) begin
          idx <= idx + 1'b1;
        end
      end
      S_APPLY: begin
        if (hit) begin
          status_q <= bwt_pkg::STAT_OK;
          found_q  <= 3'(hit_idx);
        end else if (op_q == bwt_pkg::OP_ADD && free_ok) begin
          found_q <= 3'(free_idx);
          if (kind_q == bwt_pkg::KIND_WATCH && !mok_q) begin
            status_q <= bwt_pkg::STAT_UNREADABLE;
          end else begin
            status_q <= bwt_pkg::STAT_OK;
          end
        end else begin
          status_q <= bwt_pkg::STAT_MISS;
          found_q  <= 3'd0;
        end
      end
      S_CHECK: begin
        changed_q <= check_changed;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control flow of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            priority if (cmd.op == bwt_pkg::OP_ADD || cmd.op == bwt_pkg::OP_REMOVE ||
                         cmd.op == bwt_pkg::OP_TOGGLE || cmd.op == bwt_pkg::OP_FIND) begin
              state <= S_SCAN;
            end else if (cmd.op == bwt_pkg::OP_CHECK && slot_in_range) begin
              state <= S_CHECK;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (slot_match || last_slot) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_RESP;
        end
        S_CHECK: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_xfer) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The block never takes a command while a response is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && rsp.valid))
    else $error("command accepted while a response was pending");

  // The scan pointer never leaves the addressed table.
  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |->
      ((kind_q == bwt_pkg::KIND_WATCH && int'(idx) < bwt_pkg::WATCH_SLOTS) ||
       (kind_q == bwt_pkg::KIND_BREAK && int'(idx) < bwt_pkg::BREAK_SLOTS)))
    else $error("scan pointer beyond the table");

  // Once a response transfer completes the block is ready for a command.
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer |=> cmd.ready)
    else $error("not ready after a response transfer");

  // Only a check can report a change, and only with status ok.
  a_change_only_check: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.changed) |->
      (op_q == bwt_pkg::OP_CHECK && rsp.status == bwt_pkg::STAT_OK))
    else $error("change reported outside a check");

  // A stored value is only rewritten by an add or a detected change.
  a_last_write: assert property (@(posedge clk) disable iff (rst)
    (wr.wop == bwt_pkg::WR_LAST) |-> (state == S_CHECK && mok_q))
    else $error("watch value written without a successful read");

endmodule

`default_nettype wire
